[hdl/bsed_pkg.sv]
// ----------------------------------------------------------------------------
// bsed_pkg
// Shared types, constants and decode helpers for the backslash escape decoder.
// ----------------------------------------------------------------------------
package bsed_pkg;

	// upper bound on decoded bytes per string, combined with the capacity register
	localparam int MAX_OUT = 4096;

	// default depth of the queue between front and back
	localparam int QUEUE_DEPTH_DEF = 4;

	// register map
	localparam logic [0:0] REG_OUT_CAPACITY = 1'd0;
	localparam logic [12:0] OUT_CAPACITY_RST = 13'd4096;

	// decode modes
	localparam logic [1:0] MODE_NORMAL = 2'd0;
	localparam logic [1:0] MODE_ESCAPE = 2'd1;
	localparam logic [1:0] MODE_OCTAL  = 2'd2;

	// character codes
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_BS     = 8'h08;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [1:0] OCT_DIGITS_MAX = 2'd3;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        out_valid;
		logic        out_last;
		logic [12:0] out_length;
		logic        truncated;
	} out_item_t;

	// per-string decode state
	typedef struct packed {
		logic [1:0]  mode;
		logic [7:0]  oval;
		logic [1:0]  odig;
		logic [12:0] cnt;
		logic        full;
	} dec_state_t;

	// one queue entry: the results caused by one input item
	typedef struct packed {
		logic [1:0]           n;
		out_item_t [2:0]      res;
	} entry_t;

	// working set while decoding one item
	typedef struct packed {
		dec_state_t st;
		entry_t     ent;
	} work_t;

	localparam dec_state_t DEC_STATE_RST = '{
		mode: MODE_NORMAL, oval: 8'd0, odig: 2'd0, cnt: 13'd0, full: 1'b0
	};

	function automatic logic is_octal(input logic [7:0] b);
		return (b[7:3] == 5'b00110);
	endfunction

	// append one result to the entry
	function automatic work_t put_result(input work_t w_in, input logic [7:0] b,
			input logic vld, input logic lst);
		work_t w;
		w = w_in;
		if (w.ent.n != 2'd3) begin
			w.ent.res[w.ent.n] = '{
				out_byte: b, out_valid: vld, out_last: lst,
				out_length: w.st.cnt, truncated: w.st.full
			};
			w.ent.n = w.ent.n + 2'd1;
		end
		return w;
	endfunction

	// emit one decoded byte unless the capacity is used up
	function automatic work_t emit_byte(input work_t w_in, input logic [7:0] b,
			input logic [12:0] lim);
		work_t w;
		w = w_in;
		if (!w.st.full) begin
			if (w.st.cnt >= lim) begin
				w.st.full = 1'b1;
			end else begin
				w.st.cnt = w.st.cnt + 13'd1;
				w = put_result(w, b, 1'b1, 1'b0);
			end
		end
		return w;
	endfunction

	// begin a new plain byte or escape
	function automatic work_t start_token(input work_t w_in, input logic [7:0] b,
			input logic [12:0] lim);
		work_t w;
		w = w_in;
		if (!w.st.full) begin
			if (w.st.cnt >= lim) begin
				w.st.full = 1'b1;
			end else if (b == CH_BSLASH) begin
				w.st.mode = MODE_ESCAPE;
			end else begin
				w = emit_byte(w, b, lim);
			end
		end
		return w;
	endfunction

endpackage

[hdl/bsed_front.sv]
// ----------------------------------------------------------------------------
// bsed_front
// Accepts source bytes, runs the escape state machine and packs the results
// of each item into one queue entry.
// ----------------------------------------------------------------------------
module bsed_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  bsed_pkg::in_item_t  in_item,
	input  logic [12:0]         out_capacity,
	input  logic                q_full,
	output logic                q_push,
	output bsed_pkg::entry_t    q_data
);
	import bsed_pkg::*;

	dec_state_t state_q;
	work_t      w;
	logic [12:0] lim;
	logic        accept;
	logic [7:0]  b;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign b        = in_item.in_byte;

	// limit in force is the smaller of the register and MAX_OUT
	assign lim = (MAX_OUT < int'(out_capacity)) ? 13'(MAX_OUT) : out_capacity;

	// decode one item
	always_comb begin
		w.st  = state_q;
		w.ent = '0;
		if (!w.st.full) begin
			case (w.st.mode)
				MODE_ESCAPE: begin
					w.st.mode = MODE_NORMAL;
					if (b == CH_N) begin
						w = emit_byte(w, CH_LF, lim);
					end else if (b == CH_T) begin
						w = emit_byte(w, CH_TAB, lim);
					end else if (b == CH_B) begin
						w = emit_byte(w, CH_BS, lim);
					end else if (b == CH_R) begin
						w = emit_byte(w, CH_CR, lim);
					end else if (b == CH_F) begin
						w = emit_byte(w, CH_FF, lim);
					end else if (is_octal(b)) begin
						w.st.oval = {5'd0, b[2:0]};
						w.st.odig = 2'd1;
						w.st.mode = MODE_OCTAL;
					end else begin
						w = emit_byte(w, b, lim);
					end
				end
				MODE_OCTAL: begin
					if (is_octal(b) && (w.st.odig < OCT_DIGITS_MAX)) begin
						// shifted value keeps its low 8 bits
						w.st.oval = {w.st.oval[4:0], b[2:0]};
						w.st.odig = w.st.odig + 2'd1;
						if (w.st.odig == OCT_DIGITS_MAX) begin
							w = emit_byte(w, w.st.oval, lim);
							w.st.mode = MODE_NORMAL;
							w.st.oval = 8'd0;
							w.st.odig = 2'd0;
						end
					end else begin
						w = emit_byte(w, w.st.oval, lim);
						w.st.mode = MODE_NORMAL;
						w.st.oval = 8'd0;
						w.st.odig = 2'd0;
						w = start_token(w, b, lim);
					end
				end
				default: begin
					w.st.mode = MODE_NORMAL;
					w = start_token(w, b, lim);
				end
			endcase
		end
		// end of string: flush a pending octal run, then the terminator
		if (in_item.in_last) begin
			if ((w.st.mode == MODE_OCTAL) && !w.st.full) begin
				w = emit_byte(w, w.st.oval, lim);
			end
			w = put_result(w, 8'd0, 1'b0, 1'b1);
		end
	end

	assign q_push = accept && (w.ent.n != 2'd0);
	assign q_data = w.ent;

	// state update on every accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DEC_STATE_RST;
		end else if (accept) begin
			if (in_item.in_last) begin
				state_q <= DEC_STATE_RST;
			end else begin
				state_q <= w.st;
			end
		end
	end

endmodule

[hdl/bsed_queue.sv]
// ----------------------------------------------------------------------------
// bsed_queue
// Small FIFO of result entries between the decode front and the output back.
// ----------------------------------------------------------------------------
module bsed_queue #(
	parameter int DEPTH = bsed_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  bsed_pkg::entry_t  wr_data,
	input  logic              pop,
	output bsed_pkg::entry_t  rd_data,
	output logic              full,
	output logic              empty
);
	import bsed_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	entry_t         mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           do_push;
	logic           do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

[hdl/bsed_back.sv]
// ----------------------------------------------------------------------------
// bsed_back
// Unpacks queue entries into single results and holds them in the output
// register until taken.
// ----------------------------------------------------------------------------
module bsed_back (
	input  logic                clk,
	input  logic                arst_n,
	input  bsed_pkg::entry_t    q_data,
	input  logic                q_empty,
	output logic                q_pop,
	output logic                out_valid,
	input  logic                out_stall,
	output bsed_pkg::out_item_t out_item
);
	import bsed_pkg::*;

	logic       valid_q;
	out_item_t  item_q;
	logic [1:0] idx_q;
	logic       load;
	logic       last_of_entry;

	assign load          = (!valid_q || !out_stall) && !q_empty;
	assign last_of_entry = ((idx_q + 2'd1) == q_data.n) || (idx_q == 2'd2);
	assign q_pop         = load && last_of_entry;

	assign out_valid = valid_q;
	assign out_item  = item_q;

	// result payload
	always_ff @(posedge clk) begin
		if (load) begin
			item_q <= q_data.res[idx_q];
		end
	end

	// output valid and position within the head entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= last_of_entry ? 2'd0 : idx_q + 2'd1;
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule

[hdl/backslash_escape_decoder_top.sv]
// Path: an accepted item is written into the queue, then its first result is loaded into the output register.
// Throughput: one item per cycle at the input while the queue is not full; the output
// register gives one result per cycle unless stalled, so an item with k results
// occupies the back part longer and the queue (four entries by default) absorbs the difference.
// Reset: arst_n clears decode state, queue and output valid at once; the
// capacity register returns to 4096.
// ----------------------------------------------------------------------------
// backslash_escape_decoder_top
// Decodes C-style backslash escapes with octal runs and a per-string capacity.
// ----------------------------------------------------------------------------
module backslash_escape_decoder_top #(
	parameter int QUEUE_DEPTH = bsed_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  bsed_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_stall,
	output bsed_pkg::out_item_t out_item,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import bsed_pkg::*;

	logic [12:0] out_capacity_q;
	logic        reg_sel;
	logic        q_push;
	logic        q_pop;
	logic        q_full;
	logic        q_empty;
	entry_t      q_wr;
	entry_t      q_rd;

	// register port
	assign pready  = 1'b1;
	assign reg_sel = (paddr[2:2] == REG_OUT_CAPACITY);
	assign prdata  = reg_sel ? {19'd0, out_capacity_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_capacity_q <= OUT_CAPACITY_RST;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			out_capacity_q <= pwdata[12:0];
		end
	end

	bsed_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_item      (in_item),
		.out_capacity (out_capacity_q),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_data       (q_wr)
	);

	bsed_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_data (q_wr),
		.pop     (q_pop),
		.rd_data (q_rd),
		.full    (q_full),
		.empty   (q_empty)
	);

	bsed_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_data    (q_rd),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives raw escaped byte strings into the backslash escape decoder. A local
// decode of every accepted item builds the queue of expected results; each
// result leaving the block is checked field by field against the oldest one.
// Capacity settings change between phases, and both handshake sides idle and
// stall at varying rates.
// ----------------------------------------------------------------------------
module testbench;
	import bsed_pkg::*;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_SEVEN = 8'h37;
	localparam int SEG_ITEMS = 20;
	localparam int NUM_SEGS  = 6;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	in_item_t    in_item = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_item_t   out_item;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// source bytes waiting to be driven, decoded bytes waiting to come out
	in_item_t  src_q[$];
	out_item_t decoded_q[$];

	int unsigned idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned err_cnt = 0;

	// local copy of the decode state and the capacity register
	logic [12:0] cap_reg = OUT_CAPACITY_RST;
	logic [1:0]  dmode = MODE_NORMAL;
	logic [7:0]  oval = '0;
	logic [1:0]  odigits = '0;
	logic [12:0] emitted = '0;
	logic        full = 1'b0;
	int unsigned step_res;

	backslash_escape_decoder_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ---------------------------------------------------------------- decode
	function automatic logic oct_digit(input logic [7:0] b);
		return (b >= CH_ZERO) && (b <= CH_SEVEN);
	endfunction

	function automatic logic [12:0] cap_limit();
		return (cap_reg > 13'(MAX_OUT)) ? 13'(MAX_OUT) : cap_reg;
	endfunction

	task automatic post_result(input logic [7:0] b, input logic vld, input logic lst);
		out_item_t r;
		if (step_res < 3) begin
			r.out_byte   = b;
			r.out_valid  = vld;
			r.out_last   = lst;
			r.out_length = emitted;
			r.truncated  = full;
			decoded_q.push_back(r);
			step_res++;
		end
	endtask

	task automatic emit_decoded(input logic [7:0] b);
		if (!full) begin
			if (emitted >= cap_limit()) begin
				full = 1'b1;
			end else begin
				emitted = emitted + 13'd1;
				post_result(b, 1'b1, 1'b0);
			end
		end
	endtask

	// a plain byte or the start of an escape
	task automatic open_token(input logic [7:0] b);
		if (!full) begin
			if (emitted >= cap_limit()) begin
				full = 1'b1;
			end else if (b == CH_BSLASH) begin
				dmode = MODE_ESCAPE;
			end else begin
				emit_decoded(b);
			end
		end
	endtask

	task automatic decode_item(input in_item_t it);
		logic [7:0] b;
		b = it.in_byte;
		step_res = 0;
		if (!full) begin
			case (dmode)
				MODE_ESCAPE: begin
					dmode = MODE_NORMAL;
					case (b)
						CH_N: emit_decoded(CH_LF);
						CH_T: emit_decoded(CH_TAB);
						CH_B: emit_decoded(CH_BS);
						CH_R: emit_decoded(CH_CR);
						CH_F: emit_decoded(CH_FF);
						default: begin
							if (oct_digit(b)) begin
								oval = b - CH_ZERO;
								odigits = 2'd1;
								dmode = MODE_OCTAL;
							end else begin
								emit_decoded(b);
							end
						end
					endcase
				end
				MODE_OCTAL: begin
					if (oct_digit(b) && odigits < OCT_DIGITS_MAX) begin
						oval = 8'((oval << 3) + (b - CH_ZERO));
						odigits = odigits + 2'd1;
						if (odigits >= OCT_DIGITS_MAX) begin
							emit_decoded(oval);
							dmode = MODE_NORMAL;
							oval = '0;
							odigits = '0;
						end
					end else begin
						emit_decoded(oval);
						dmode = MODE_NORMAL;
						oval = '0;
						odigits = '0;
						open_token(b);
					end
				end
				default: begin
					dmode = MODE_NORMAL;
					open_token(b);
				end
			endcase
		end
		// end of string: flush a pending octal value, then the terminator
		if (it.in_last) begin
			if (dmode == MODE_OCTAL && !full)
				emit_decoded(oval);
			post_result(8'h00, 1'b0, 1'b1);
			dmode = MODE_NORMAL;
			oval = '0;
			odigits = '0;
			emitted = '0;
			full = 1'b0;
		end
	endtask

	// ---------------------------------------------------------------- driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				decode_item(in_item);
			if (!in_valid || !in_stall) begin
				if (src_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
					in_item <= src_q.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------- monitor
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n) begin
			out_stall <= ($urandom_range(99) < stall_pct);
			if (out_valid && !out_stall) begin
				if (decoded_q.size() == 0) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("unexpected result: byte %h vld %b last %b len %0d trunc %b",
							out_item.out_byte, out_item.out_valid, out_item.out_last,
							out_item.out_length, out_item.truncated);
				end else begin
					want = decoded_q.pop_front();
					if (out_item.out_byte !== want.out_byte ||
							out_item.out_valid !== want.out_valid ||
							out_item.out_last !== want.out_last ||
							out_item.out_length !== want.out_length ||
							out_item.truncated !== want.truncated) begin
						err_cnt++;
						if (err_cnt <= 10)
							$display("mismatch: exp byte %h vld %b last %b len %0d trunc %b, got byte %h vld %b last %b len %0d trunc %b",
								want.out_byte, want.out_valid, want.out_last,
								want.out_length, want.truncated,
								out_item.out_byte, out_item.out_valid, out_item.out_last,
								out_item.out_length, out_item.truncated);
					end
				end
			end
		end
	end

	// ---------------------------------------------------------------- stimulus
	function automatic void queue_byte(input logic [7:0] b, input logic lst);
		in_item_t it;
		it.in_byte = b;
		it.in_last = lst;
		src_q.push_back(it);
	endfunction

	task automatic queue_text(input string s, input logic ends);
		for (int i = 0; i < s.len(); i++)
			queue_byte(s[i], ends && (i == s.len() - 1));
	endtask

	// wait until every item is in and every result is out, then let the
	// pipeline settle so items with no result are finished too
	task automatic drain();
		while (src_q.size() > 0 || in_valid || decoded_q.size() > 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_capacity(input logic [12:0] v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_OUT_CAPACITY, 2'b00};
		pwdata <= 32'(v);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		cap_reg = v;
	endtask

	// one random string, mostly well-formed escapes; returns bytes queued
	function automatic int queue_rand_string();
		logic [7:0] bytes_q[$];
		logic [7:0] simple[5];
		int ntok;
		int r;
		simple = '{CH_N, CH_T, CH_B, CH_R, CH_F};
		ntok = $urandom_range(1, 8);
		for (int t = 0; t < ntok; t++) begin
			r = $urandom_range(99);
			if (r < 40) begin
				bytes_q.push_back(8'($urandom_range(255)));
			end else if (r < 55) begin
				bytes_q.push_back(CH_BSLASH);
				bytes_q.push_back(simple[$urandom_range(4)]);
			end else if (r < 75) begin
				bytes_q.push_back(CH_BSLASH);
				repeat ($urandom_range(1, 4))
					bytes_q.push_back(CH_ZERO + 8'($urandom_range(7)));
			end else if (r < 85) begin
				bytes_q.push_back(CH_BSLASH);
				bytes_q.push_back(8'($urandom_range(255)));
			end else begin
				// noise around the special characters
				case ($urandom_range(3))
					0: bytes_q.push_back(CH_BSLASH);
					1: bytes_q.push_back(CH_ZERO + 8'($urandom_range(7)));
					2: bytes_q.push_back(simple[$urandom_range(4)]);
					default: bytes_q.push_back(8'($urandom_range(255)));
				endcase
			end
		end
		// sometimes a lone backslash ends the string
		if ($urandom_range(9) == 0)
			bytes_q.push_back(CH_BSLASH);
		foreach (bytes_q[i])
			queue_byte(bytes_q[i], i == bytes_q.size() - 1);
		return bytes_q.size();
	endfunction

	initial begin
		logic [12:0] caps[NUM_SEGS];
		int seg_items;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: byte extremes, every escape, octal runs, lone backslash
		queue_byte(8'h00, 1'b0);
		queue_byte(8'hFF, 1'b0);
		queue_text("\\n\\t\\b\\r\\f\\3771\\8\\5", 1'b1);
		queue_text("\\", 1'b1);
		drain();

		// capacity reached while starting a new byte
		write_capacity(13'd2);
		queue_text("abc", 1'b1);
		drain();

		// zero capacity
		write_capacity(13'd0);
		queue_text("x", 1'b1);
		drain();

		// capacity lowered in the middle of a string
		write_capacity(13'(MAX_OUT));
		queue_text("a\\", 1'b0);
		drain();
		write_capacity(13'd1);
		queue_text("c", 1'b1);
		drain();

		// random segments, each with its own capacity and idling mix
		caps = '{13'd3, 13'd0, 13'(MAX_OUT), 13'd1, 13'd5, 13'($urandom_range(0, 12))};
		for (int s = 0; s < NUM_SEGS; s++) begin
			write_capacity(caps[s]);
			case (s % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 56; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 56; end
				default: begin idle_pct = 20; stall_pct = 20; end
			endcase
			seg_items = 0;
			while (seg_items < SEG_ITEMS)
				seg_items += queue_rand_string();
			drain();
		end

		repeat (10) @(negedge clk);
		if (decoded_q.size() > 0) begin
			err_cnt += decoded_q.size();
			$display("%0d expected results never arrived", decoded_q.size());
		end
		if (err_cnt == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// run limit
	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

[filelist.f]
hdl/bsed_pkg.sv
hdl/bsed_front.sv
hdl/bsed_queue.sv
hdl/bsed_back.sv
hdl/backslash_escape_decoder_top.sv
bench/testbench.sv
